// ===== design/c2d_pkg.sv =====
// Constants, codes and field layouts for the stride-1 valid convolution block.
package c2d_pkg;

    localparam int MAX_HEIGHT   = 32;
    localparam int MAX_WIDTH    = 32;
    localparam int MAX_CHANNELS = 8;
    localparam int MAX_KERNEL   = 5;
    localparam int MAX_FILTERS  = 16;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 5;
    localparam int CHAN_W  = 3;
    localparam int FILT_W  = 4;
    localparam int VALUE_W = 16;
    localparam int FUNC_W  = 2;
    localparam int SUM_W   = 32;

    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 32;

    localparam int ACT_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int WGT_DEPTH = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS * MAX_FILTERS;
    localparam int ACT_AW    = $clog2(ACT_DEPTH);
    localparam int WGT_AW    = $clog2(WGT_DEPTH);
    localparam int KIDX_W    = $clog2(MAX_KERNEL * MAX_KERNEL);
    localparam int KCNT_W    = 3;

    localparam int PROD_W = 2 * VALUE_W;
    localparam int ACC_W  = 40;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ACT_WR = 2'd0,
        FUNC_WGT_WR = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_IN_HEIGHT     = 3'd0,
        REG_IN_WIDTH      = 3'd1,
        REG_IN_CHANNELS   = 3'd2,
        REG_KERNEL_HEIGHT = 3'd3,
        REG_KERNEL_WIDTH  = 3'd4,
        REG_FILTER_COUNT  = 3'd5,
        REG_SPARE6        = 3'd6,
        REG_SPARE7        = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [FILT_W-1:0]         filt;
        logic [CHAN_W-1:0]         chan;
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
    } in_item_t;

endpackage

// ===== design/conv2d_valid_mac_top.sv =====
// Stride-1 valid 2D convolution with activation and weight memories and one shared MAC.
//
//   Channel   Direction  Handshake                 Payload
//   s_        in         s_tvalid / s_tready       tdata: row, col, chan, filt, value
//                                                  tuser: func
//   m_        out        m_tvalid / m_tready       tdata: sum; tuser: index_error
//   apb       in         psel / penable / pready   paddr, pwdata, prdata
//
// A write item is written to its memory as it is transferred. A query walks
// kernel_height * kernel_width * in_channels taps, one read of each memory per
// cycle through the single multiplier, then drains the read, product and
// accumulate stages and saturates the sum. An out-of-range query goes straight
// to its result.
// Reset loads default sizes and clears control state; the memories are not cleared.
// A new item is taken while a result waits in the output register; a query that
// finishes before that result has been transferred holds until it has.
module conv2d_valid_mac_top
    import c2d_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // row, col, chan, filt, value, zero pad
    input  logic [FUNC_W-1:0]      s_tuser,   // func
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // sum
    output logic [0:0]             m_tuser,   // index_error
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32'sh7FFF_FFFF - 32'sd1);

    logic [5:0] in_height_reg;
    logic [5:0] in_width_reg;
    logic [3:0] in_channels_reg;
    logic [2:0] kernel_height_reg;
    logic [2:0] kernel_width_reg;
    logic [4:0] filter_count_reg;

    state_t                   state_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [COL_W-1:0]         col_reg;
    logic [FILT_W-1:0]        filt_reg;
    logic [KCNT_W-1:0]        dy_reg;
    logic [KCNT_W-1:0]        dx_reg;
    logic [CHAN_W-1:0]        c_reg;
    logic                     err_reg;
    logic                     rd_vld_reg;
    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     m_tvalid_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;
    logic                     m_tuser_reg;

    logic [VALUE_W-1:0] act_mem [ACT_DEPTH];
    logic [VALUE_W-1:0] wgt_mem [WGT_DEPTH];
    logic [VALUE_W-1:0] act_rdata_reg;
    logic [VALUE_W-1:0] wgt_rdata_reg;

    in_item_t          item;
    func_t             func;
    logic              in_xfer;
    logic              cfg_wr;
    logic [5:0]        ih_eff;
    logic [5:0]        iw_eff;
    logic [3:0]        ic_eff;
    logic [2:0]        kh_eff;
    logic [2:0]        kw_eff;
    logic [4:0]        fc_eff;
    logic [5:0]        oh;
    logic [5:0]        ow;
    logic              query_bad;
    logic              act_we;
    logic              wgt_we;
    logic [ACT_AW-1:0] act_waddr;
    logic [WGT_AW-1:0] wgt_waddr;
    logic [KIDX_W-1:0] wr_kidx;
    logic [ACT_AW-1:0] act_raddr;
    logic [WGT_AW-1:0] wgt_raddr;
    logic [KIDX_W-1:0] rd_kidx;
    logic [ROW_W-1:0]  tap_y;
    logic [COL_W-1:0]  tap_x;
    logic              last_c;
    logic              last_dx;
    logic              last_dy;
    logic              out_free;
    logic              out_load;
    logic [SUM_W-1:0]  sat_sum;

    assign item    = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
    assign func    = func_t'(s_tuser);
    assign in_xfer = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Effective sizes: zero reads as one, oversize values read as the maximum.
    always_comb begin
        ih_eff = (in_height_reg == '0) ? 6'd1 :
                 (in_height_reg > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : in_height_reg;
        iw_eff = (in_width_reg == '0) ? 6'd1 :
                 (in_width_reg > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : in_width_reg;
        ic_eff = (in_channels_reg == '0) ? 4'd1 :
                 (in_channels_reg > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : in_channels_reg;
        kh_eff = (kernel_height_reg == '0) ? 3'd1 :
                 (kernel_height_reg > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kernel_height_reg;
        kw_eff = (kernel_width_reg == '0) ? 3'd1 :
                 (kernel_width_reg > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kernel_width_reg;
        fc_eff = (filter_count_reg == '0) ? 5'd1 :
                 (filter_count_reg > 5'(MAX_FILTERS)) ? 5'(MAX_FILTERS) : filter_count_reg;
        oh = ({3'd0, kh_eff} <= ih_eff) ? ih_eff - {3'd0, kh_eff} + 6'd1 : 6'd0;
        ow = ({3'd0, kw_eff} <= iw_eff) ? iw_eff - {3'd0, kw_eff} + 6'd1 : 6'd0;
        query_bad = ({1'b0, item.row} >= oh) || ({1'b0, item.col} >= ow) ||
                    ({1'b0, item.filt} >= fc_eff);
    end

    always_comb begin
        act_we = in_xfer && (func == FUNC_ACT_WR) &&
                 ({1'b0, item.row} < ih_eff) && ({1'b0, item.col} < iw_eff) &&
                 ({1'b0, item.chan} < ic_eff);
        wgt_we = in_xfer && (func == FUNC_WGT_WR) &&
                 (item.row < {2'd0, kh_eff}) && (item.col < {2'd0, kw_eff}) &&
                 ({1'b0, item.chan} < ic_eff) && ({1'b0, item.filt} < fc_eff);
        act_waddr = {item.row, item.col, item.chan};
        wr_kidx   = KIDX_W'(item.row[KCNT_W-1:0]) * KIDX_W'(MAX_KERNEL) +
                    KIDX_W'(item.col[KCNT_W-1:0]);
        wgt_waddr = WGT_AW'({wr_kidx, item.chan, item.filt});
    end

    always_comb begin
        tap_y     = row_reg + ROW_W'(dy_reg);
        tap_x     = col_reg + COL_W'(dx_reg);
        act_raddr = {tap_y, tap_x, c_reg};
        rd_kidx   = KIDX_W'(dy_reg) * KIDX_W'(MAX_KERNEL) + KIDX_W'(dx_reg);
        wgt_raddr = WGT_AW'({rd_kidx, c_reg, filt_reg});
        last_c    = (c_reg == CHAN_W'(ic_eff - 4'd1));
        last_dx   = (dx_reg == kw_eff - 3'd1);
        last_dy   = (dy_reg == kh_eff - 3'd1);
    end

    always_ff @(posedge aclk) begin
        if (act_we) begin
            act_mem[act_waddr] <= item.value;
        end
        act_rdata_reg <= act_mem[act_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wgt_we) begin
            wgt_mem[wgt_waddr] <= item.value;
        end
        wgt_rdata_reg <= wgt_mem[wgt_raddr];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= $signed(act_rdata_reg) * $signed(wgt_rdata_reg);
    end

    always_comb begin
        if (acc_reg > SAT_MAX) begin
            sat_sum = SAT_MAX[SUM_W-1:0];
        end else if (acc_reg < SAT_MIN) begin
            sat_sum = SAT_MIN[SUM_W-1:0];
        end else begin
            sat_sum = acc_reg[SUM_W-1:0];
        end
        out_free = !m_tvalid_reg || m_tready;
        out_load = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_height_reg     <= 6'd8;
            in_width_reg      <= 6'd8;
            in_channels_reg   <= 4'd1;
            kernel_height_reg <= 3'd3;
            kernel_width_reg  <= 3'd3;
            filter_count_reg  <= 5'd1;
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[4:2]))
                REG_IN_HEIGHT:     in_height_reg     <= pwdata[5:0];
                REG_IN_WIDTH:      in_width_reg      <= pwdata[5:0];
                REG_IN_CHANNELS:   in_channels_reg   <= pwdata[3:0];
                REG_KERNEL_HEIGHT: kernel_height_reg <= pwdata[2:0];
                REG_KERNEL_WIDTH:  kernel_width_reg  <= pwdata[2:0];
                REG_FILTER_COUNT:  filter_count_reg  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[4:2]))
            REG_IN_HEIGHT:     prdata = PDATA_W'(in_height_reg);
            REG_IN_WIDTH:      prdata = PDATA_W'(in_width_reg);
            REG_IN_CHANNELS:   prdata = PDATA_W'(in_channels_reg);
            REG_KERNEL_HEIGHT: prdata = PDATA_W'(kernel_height_reg);
            REG_KERNEL_WIDTH:  prdata = PDATA_W'(kernel_width_reg);
            REG_FILTER_COUNT:  prdata = PDATA_W'(filter_count_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            err_reg      <= 1'b0;
            dy_reg       <= '0;
            dx_reg       <= '0;
            c_reg        <= '0;
            acc_reg      <= '0;
        end else begin
            rd_vld_reg   <= (state_reg == ST_RUN);
            prod_vld_reg <= rd_vld_reg;
            if (prod_vld_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer && (func == FUNC_QUERY)) begin
                        row_reg  <= item.row;
                        col_reg  <= item.col;
                        filt_reg <= item.filt;
                        dy_reg   <= '0;
                        dx_reg   <= '0;
                        c_reg    <= '0;
                        acc_reg  <= '0;
                        err_reg  <= query_bad;
                        state_reg <= query_bad ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (last_c) begin
                        c_reg <= '0;
                        if (last_dx) begin
                            dx_reg <= '0;
                            if (last_dy) begin
                                dy_reg    <= '0;
                                state_reg <= ST_DRAIN;
                            end else begin
                                dy_reg <= dy_reg + 3'd1;
                            end
                        end else begin
                            dx_reg <= dx_reg + 3'd1;
                        end
                    end else begin
                        c_reg <= c_reg + 3'd1;
                    end
                end
                ST_DRAIN: begin
                    if (!rd_vld_reg && !prod_vld_reg) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= err_reg ? '0 : sat_sum;
                        m_tuser_reg  <= err_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_write_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (act_we || wgt_we) |-> (state_reg == ST_IDLE))
        else $error("memory write outside idle");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untransferred result");

    a_done_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (!rd_vld_reg && !prod_vld_reg))
        else $error("result stage reached with taps in flight");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg) |-> (m_tdata_reg == '0))
        else $error("index error result carries a nonzero sum");

endmodule

// ===== verif/conv2d_valid_mac_top_tb.sv =====
// Self-checking testbench for the stride-1 valid convolution block, with its own predictor.
module conv2d_valid_mac_top_tb;
    import c2d_pkg::*;

    localparam int  ITEMS_PER_PHASE = 235;
    localparam int  PHASE_COUNT     = 8;
    localparam int  SETTLE_CYCLES   = 10;
    localparam int  TAIL_CYCLES     = 30;
    localparam int  WATCHDOG_LIMIT  = 4000;
    localparam longint SUM_MAX      = 64'sd2147483647;
    localparam longint SUM_MIN      = -64'sd2147483648;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             err;
    } conv_result_t;

    typedef struct {
        bit           is_cfg;
        reg_idx_t     ridx;
        int unsigned  rval;
        func_t        fn;
        in_item_t     it;
        bit           typed;
        conv_result_t want;
    } dir_step_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int unsigned    cfg_raw [6];
    logic [15:0]    act_mem [ACT_DEPTH];
    bit             act_set [ACT_DEPTH];
    logic [15:0]    wgt_mem [WGT_DEPTH];
    bit             wgt_set [WGT_DEPTH];
    conv_result_t   pending_sums [$];
    dir_step_t      steps [$];
    int             mismatches = 0;
    int             sent_items = 0;
    int             idle_cycles = 0;
    bit             calm = 1'b0;

    conv2d_valid_mac_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned cfg_mask(reg_idx_t r);
        case (r)
            REG_IN_HEIGHT, REG_IN_WIDTH:          return 32'h3F;
            REG_IN_CHANNELS:                      return 32'hF;
            REG_KERNEL_HEIGHT, REG_KERNEL_WIDTH:  return 32'h7;
            REG_FILTER_COUNT:                     return 32'h1F;
            default:                              return 32'h0;
        endcase
    endfunction

    function automatic int eff_cfg(reg_idx_t r);
        int top;
        int v;
        case (r)
            REG_IN_HEIGHT:     top = MAX_HEIGHT;
            REG_IN_WIDTH:      top = MAX_WIDTH;
            REG_IN_CHANNELS:   top = MAX_CHANNELS;
            REG_KERNEL_HEIGHT: top = MAX_KERNEL;
            REG_KERNEL_WIDTH:  top = MAX_KERNEL;
            default:           top = MAX_FILTERS;
        endcase
        v = int'(cfg_raw[r]);
        if (v < 1) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic int out_rows();
        int ih;
        int kh;
        ih = eff_cfg(REG_IN_HEIGHT);
        kh = eff_cfg(REG_KERNEL_HEIGHT);
        return (kh <= ih) ? ih - kh + 1 : 0;
    endfunction

    function automatic int out_cols();
        int iw;
        int kw;
        iw = eff_cfg(REG_IN_WIDTH);
        kw = eff_cfg(REG_KERNEL_WIDTH);
        return (kw <= iw) ? iw - kw + 1 : 0;
    endfunction

    function automatic int act_index(int y, int x, int c);
        return (y * MAX_WIDTH + x) * MAX_CHANNELS + c;
    endfunction

    function automatic int wgt_index(int dy, int dx, int c, int f);
        return ((dy * MAX_KERNEL + dx) * MAX_CHANNELS + c) * MAX_FILTERS + f;
    endfunction

    function automatic in_item_t make_item(int row, int col, int chan, int filt,
                                           logic [15:0] value);
        in_item_t it;
        it.row   = ROW_W'(row);
        it.col   = COL_W'(col);
        it.chan  = CHAN_W'(chan);
        it.filt  = FILT_W'(filt);
        it.value = value;
        return it;
    endfunction

    // Applies one accepted item to the mirrored stores and works out its result.
    function automatic void conv_step(input func_t fn, input in_item_t it,
                                      output bit has_res, output conv_result_t res);
        int     ih, iw, ic, kh, kw, fc;
        int     row, col, chan, filt;
        int     ai, wi;
        longint acc;
        ih = eff_cfg(REG_IN_HEIGHT);
        iw = eff_cfg(REG_IN_WIDTH);
        ic = eff_cfg(REG_IN_CHANNELS);
        kh = eff_cfg(REG_KERNEL_HEIGHT);
        kw = eff_cfg(REG_KERNEL_WIDTH);
        fc = eff_cfg(REG_FILTER_COUNT);
        row  = int'(it.row);
        col  = int'(it.col);
        chan = int'(it.chan);
        filt = int'(it.filt);
        has_res = 1'b0;
        res = '0;
        acc = 0;
        case (fn)
            FUNC_ACT_WR: begin
                if (row < ih && col < iw && chan < ic) begin
                    ai = act_index(row, col, chan);
                    act_mem[ai] = it.value;
                    act_set[ai] = 1'b1;
                end
            end
            FUNC_WGT_WR: begin
                if (row < kh && col < kw && chan < ic && filt < fc) begin
                    wi = wgt_index(row, col, chan, filt);
                    wgt_mem[wi] = it.value;
                    wgt_set[wi] = 1'b1;
                end
            end
            FUNC_QUERY: begin
                has_res = 1'b1;
                if (row >= out_rows() || col >= out_cols() || filt >= fc) begin
                    res.err = 1'b1;
                end else begin
                    for (int dy = 0; dy < kh; dy++)
                        for (int dx = 0; dx < kw; dx++)
                            if (row + dy < ih && col + dx < iw)
                                for (int c = 0; c < ic; c++) begin
                                    ai = act_index(row + dy, col + dx, c);
                                    wi = wgt_index(dy, dx, c, filt);
                                    acc += longint'($signed(act_mem[ai]))
                                         * longint'($signed(wgt_mem[wi]));
                                end
                    if (acc > SUM_MAX)
                        res.sum = 32'h7FFF_FFFF;
                    else if (acc < SUM_MIN)
                        res.sum = 32'h8000_0000;
                    else
                        res.sum = acc[31:0];
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 48);
    endfunction

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    task automatic push_item(func_t fn, in_item_t it, bit typed, conv_result_t want);
        int           n;
        bit           has_res;
        conv_result_t res;
        n = calm ? 0 : gap_len();
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (n) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = IN_DATA_W'(it);
        s_tuser  = fn;
        do @(posedge aclk); while (!s_tready);
        conv_step(fn, it, has_res, res);
        sent_items++;
        if (has_res)
            pending_sums = {pending_sums, (typed ? want : res)};
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_sums.size() != 0)
            @(posedge aclk);
    endtask

    task automatic cfg_write(reg_idx_t r, int unsigned v);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {r, 2'b00};
        pwdata  = v;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        cfg_raw[r] = v & cfg_mask(r);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reconfigure(int unsigned ih, int unsigned iw, int unsigned ic,
                               int unsigned kh, int unsigned kw, int unsigned fc);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_write(REG_IN_HEIGHT, ih);
        cfg_write(REG_IN_WIDTH, iw);
        cfg_write(REG_IN_CHANNELS, ic);
        cfg_write(REG_KERNEL_HEIGHT, kh);
        cfg_write(REG_KERNEL_WIDTH, kw);
        cfg_write(REG_FILTER_COUNT, fc);
    endtask

    // Writes every activation and weight that a query at this position reads
    // and that has never been written.
    task automatic fill_taps(int row, int col, int filt);
        int ai;
        int wi;
        for (int dy = 0; dy < eff_cfg(REG_KERNEL_HEIGHT); dy++)
            for (int dx = 0; dx < eff_cfg(REG_KERNEL_WIDTH); dx++)
                for (int c = 0; c < eff_cfg(REG_IN_CHANNELS); c++) begin
                    ai = act_index(row + dy, col + dx, c);
                    wi = wgt_index(dy, dx, c, filt);
                    if (!act_set[ai])
                        push_item(FUNC_ACT_WR, make_item(row + dy, col + dx, c, 0, rand_value()),
                                  1'b0, '0);
                    if (!wgt_set[wi])
                        push_item(FUNC_WGT_WR, make_item(dy, dx, c, filt, rand_value()),
                                  1'b0, '0);
                end
    endtask

    function automatic int near_pick(int span);
        if (span <= 0) return 0;
        if ($urandom_range(0, 3) != 0) return $urandom_range(0, (span > 2) ? 1 : span - 1);
        return $urandom_range(0, span - 1);
    endfunction

    task automatic random_item();
        int    r, oh, ow, fc;
        int    row, col, chan, filt;
        func_t fn;
        oh = out_rows();
        ow = out_cols();
        fc = eff_cfg(REG_FILTER_COUNT);
        r  = $urandom_range(0, 99);
        if (r < 55 && oh > 0 && ow > 0) begin
            row  = near_pick(oh);
            col  = near_pick(ow);
            filt = near_pick(fc);
            fill_taps(row, col, filt);
            push_item(FUNC_QUERY, make_item(row, col, $urandom_range(0, 7), filt, rand_value()),
                      1'b0, '0);
        end else if (r < 75) begin
            if ($urandom_range(0, 1) == 0)
                push_item(FUNC_ACT_WR,
                          make_item($urandom_range(0, eff_cfg(REG_IN_HEIGHT) - 1),
                                    $urandom_range(0, eff_cfg(REG_IN_WIDTH) - 1),
                                    $urandom_range(0, eff_cfg(REG_IN_CHANNELS) - 1),
                                    $urandom_range(0, 15), rand_value()), 1'b0, '0);
            else
                push_item(FUNC_WGT_WR,
                          make_item($urandom_range(0, eff_cfg(REG_KERNEL_HEIGHT) - 1),
                                    $urandom_range(0, eff_cfg(REG_KERNEL_WIDTH) - 1),
                                    $urandom_range(0, eff_cfg(REG_IN_CHANNELS) - 1),
                                    $urandom_range(0, fc - 1), rand_value()), 1'b0, '0);
        end else begin
            fn   = func_t'($urandom_range(0, 3));
            row  = $urandom_range(0, 31);
            col  = $urandom_range(0, 31);
            chan = $urandom_range(0, 7);
            filt = $urandom_range(0, 15);
            if (fn == FUNC_QUERY && row < oh && col < ow && filt < fc)
                fill_taps(row, col, filt);
            push_item(fn, make_item(row, col, chan, filt, rand_value()), 1'b0, '0);
        end
    endtask

    task automatic add_cfg(reg_idx_t r, int unsigned v);
        dir_step_t s;
        s.is_cfg = 1'b1;
        s.ridx   = r;
        s.rval   = v;
        s.fn     = FUNC_NONE;
        s.it     = '0;
        s.typed  = 1'b0;
        s.want   = '0;
        steps = {steps, s};
    endtask

    task automatic add_item(func_t fn, int row, int col, int chan, int filt,
                            logic [15:0] value, bit typed, logic [31:0] sum, bit err);
        dir_step_t s;
        s.is_cfg   = 1'b0;
        s.ridx     = REG_IN_HEIGHT;
        s.rval     = 0;
        s.fn       = fn;
        s.it       = make_item(row, col, chan, filt, value);
        s.typed    = typed;
        s.want.sum = sum;
        s.want.err = err;
        steps = {steps, s};
    endtask

    always @(posedge aclk) begin
        conv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected result sum=%h err=%b", m_tdata, m_tuser));
            end else begin
                want = pending_sums.pop_front();
                if (m_tdata !== want.sum)
                    report_mismatch($sformatf("sum %h, want %h", m_tdata, want.sum));
                if (m_tuser[0] !== want.err)
                    report_mismatch($sformatf("index_error %b, want %b", m_tuser, want.err));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int run;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            run = $urandom_range(1, 12);
            m_tready = 1'b1;
            repeat (run) @(negedge aclk);
            run = calm ? 0 : gap_len();
            if (run > 0) begin
                m_tready = 1'b0;
                repeat (run) @(negedge aclk);
            end
        end
    end

    initial begin
        int phase_end;
        cfg_raw = '{8, 8, 1, 3, 3, 1};

        // Default sizes after reset: 8x8 input, 3x3 kernel, one channel, one filter.
        add_item(FUNC_QUERY, 6, 0, 0, 0, 16'h0000, 1'b1, 32'h0, 1'b1);
        add_item(FUNC_QUERY, 0, 6, 0, 0, 16'h0000, 1'b1, 32'h0, 1'b1);
        add_item(FUNC_QUERY, 0, 0, 0, 1, 16'h0000, 1'b1, 32'h0, 1'b1);
        add_item(FUNC_QUERY, 31, 31, 7, 15, 16'hFFFF, 1'b1, 32'h0, 1'b1);
        add_item(FUNC_NONE, 31, 31, 7, 15, 16'hFFFF, 1'b0, 32'h0, 1'b0);
        add_item(FUNC_ACT_WR, 31, 31, 7, 0, 16'h7FFF, 1'b0, 32'h0, 1'b0);
        add_item(FUNC_WGT_WR, 3, 0, 0, 0, 16'h8000, 1'b0, 32'h0, 1'b0);

        // A 1x1 kernel over three channels drives the sum into both saturation limits.
        add_cfg(REG_IN_CHANNELS, 3);
        add_cfg(REG_KERNEL_HEIGHT, 0);
        add_cfg(REG_KERNEL_WIDTH, 1);
        add_cfg(REG_FILTER_COUNT, 2);
        for (int c = 0; c < 3; c++) begin
            add_item(FUNC_ACT_WR, 0, 0, c, 0, 16'h8000, 1'b0, 32'h0, 1'b0);
            add_item(FUNC_WGT_WR, 0, 0, c, 0, 16'h8000, 1'b0, 32'h0, 1'b0);
            add_item(FUNC_WGT_WR, 0, 0, c, 1, 16'h7FFF, 1'b0, 32'h0, 1'b0);
        end
        add_item(FUNC_QUERY, 0, 0, 0, 0, 16'h0000, 1'b1, 32'h7FFF_FFFF, 1'b0);
        add_item(FUNC_QUERY, 0, 0, 0, 1, 16'h0000, 1'b1, 32'h8000_0000, 1'b0);
        add_item(FUNC_QUERY, 8, 0, 0, 0, 16'h0000, 1'b1, 32'h0, 1'b1);
        add_item(FUNC_QUERY, 0, 0, 0, 2, 16'h0000, 1'b1, 32'h0, 1'b1);
        add_item(FUNC_ACT_WR, 0, 0, 1, 0, 16'h0123, 1'b0, 32'h0, 1'b0);
        add_item(FUNC_QUERY, 0, 0, 0, 1, 16'h0000, 1'b0, 32'h0, 1'b0);

        // A kernel taller than the input leaves no output positions at all.
        add_cfg(REG_IN_HEIGHT, 0);
        add_cfg(REG_KERNEL_HEIGHT, 5);
        add_item(FUNC_QUERY, 0, 0, 0, 0, 16'h0000, 1'b1, 32'h0, 1'b1);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (steps[i]) begin
            if (steps[i].is_cfg) begin
                wait_drained();
                repeat (SETTLE_CYCLES) @(posedge aclk);
                cfg_write(steps[i].ridx, steps[i].rval);
            end else begin
                push_item(steps[i].fn, steps[i].it, steps[i].typed, steps[i].want);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            calm = (p % 3 == 1);
            case (p)
                0:       reconfigure(63, 63, 15, 7, 7, 31);
                1:       reconfigure(0, 0, 0, 0, 0, 0);
                2:       reconfigure(6, 5, 2, 3, 2, 3);
                3:       reconfigure(4, 4, 1, 5, 5, 2);
                4:       reconfigure(32, 32, 8, 5, 5, 16);
                default: reconfigure($urandom_range(1, 12), $urandom_range(1, 12),
                                     $urandom_range(1, 4), $urandom_range(1, 5),
                                     $urandom_range(1, 5), $urandom_range(1, 16));
            endcase
            phase_end = sent_items + ITEMS_PER_PHASE;
            while (sent_items < phase_end) begin
                random_item();
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_sums.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_sums.size()));
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
